[hw/rtl/fsgs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Falling sand grid step: shared package
// Port field widths, command and register codes, and the structures that
// travel between the top level and the grid engine.
// ----------------------------------------------------------------------------
package fsgs_pkg;

   // Port field widths.
   localparam int CMD_W       = 2;
   localparam int COL_W       = 7;
   localparam int ROW_W       = 6;
   localparam int VALUE_W     = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int COLS_REG_W  = 8;
   localparam int ROWS_REG_W  = 7;
   localparam int LFSR_W      = 32;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_COLS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_ROWS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANDOM_SEED = 2'd2;

   // Register reset values and the direction generator's feedback mask.
   localparam int                COLS_DEFAULT = 100;
   localparam int                ROWS_DEFAULT = 60;
   localparam logic [LFSR_W-1:0] SEED_DEFAULT = 32'd1;
   localparam logic [LFSR_W-1:0] LFSR_TAPS    = 32'h8020_0003;

   // One command as accepted from the input channel.
   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [COL_W-1:0]   col;
      logic [ROW_W-1:0]   row;
      logic [VALUE_W-1:0] value;
   } cmd_req_type;

   // One result as handed to the output channel.
   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic               out_of_range;
   } result_type;

   // Engine status seen by the top level.
   typedef struct packed {
      logic idle;
      logic done;
   } eng_status_type;

endpackage

[hw/rtl/falling_sand_grid_step.sv]
// A write, an unused command or an out-of-range access passes its result through the engine's
// result register and the output register; an in-range read first passes the read state. One
// item is in work at a time. A tick visits each active cell once: an empty cell or bottom-row
// grain settles in the self state; another also visits the below state and maybe the first and
// second side states. The retiring bank is cleared one entry a cycle while the scan leads the
// clear by two columns. After reset a clearing pass stalls the input; register writes are taken.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Falling sand grid step: top level
// Configuration registers, the direction generator, the grid engine and the
// output register of the result channel.
// ----------------------------------------------------------------------------
module falling_sand_grid_step #(
   parameter int MAX_COLS  = 128,
   parameter int MAX_ROWS  = 64,
   parameter int CELL_BITS = 9
) (
   input  logic                                clock,
   input  logic                                reset,
   // Command channel.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fsgs_pkg::CMD_W-1:0]          req_cmd,
   input  logic [fsgs_pkg::COL_W-1:0]          req_col,
   input  logic [fsgs_pkg::ROW_W-1:0]          req_row,
   input  logic [fsgs_pkg::VALUE_W-1:0]        req_value,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fsgs_pkg::VALUE_W-1:0]        rsp_read_value,
   output logic                                rsp_out_of_range,
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fsgs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fsgs_pkg::CSR_DATA_W-1:0]     csr_data
);

   import fsgs_pkg::*;

   localparam int ACW        = $clog2(MAX_COLS + 1);
   localparam int ARW        = $clog2(MAX_ROWS + 1);
   localparam int COLS_RESET = (COLS_DEFAULT > MAX_COLS) ? MAX_COLS : COLS_DEFAULT;
   localparam int ROWS_RESET = (ROWS_DEFAULT > MAX_ROWS) ? MAX_ROWS : ROWS_DEFAULT;

   logic [ACW-1:0]        active_cols_ff, active_cols_in;
   logic [ARW-1:0]        active_rows_ff, active_rows_in;
   logic [COLS_REG_W-1:0] cols_raw;
   logic [ROWS_REG_W-1:0] rows_raw;
   logic                  csr_write;
   logic                  seed_load;

   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff, rsp_in;
   logic                  rsp_free;
   logic                  res_take;
   logic                  start;
   cmd_req_type           req;
   eng_status_type        eng_status;
   result_type            eng_result;
   logic                  lfsr_step;
   logic                  lfsr_bit;

   // Configuration writes are always taken; sizes are clamped to the grid.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign cols_raw  = csr_data[COLS_REG_W-1:0];
   assign rows_raw  = csr_data[ROWS_REG_W-1:0];
   assign seed_load = csr_write && (csr_index == CSR_RANDOM_SEED);

   always_comb begin
      active_cols_in = active_cols_ff;
      active_rows_in = active_rows_ff;
      if (csr_write && csr_index == CSR_ACTIVE_COLS) begin
         if (cols_raw == '0) begin
            active_cols_in = ACW'(1);
         end else if (32'(cols_raw) > MAX_COLS) begin
            active_cols_in = ACW'(MAX_COLS);
         end else begin
            active_cols_in = ACW'(cols_raw);
         end
      end
      if (csr_write && csr_index == CSR_ACTIVE_ROWS) begin
         if (rows_raw == '0) begin
            active_rows_in = ARW'(1);
         end else if (32'(rows_raw) > MAX_ROWS) begin
            active_rows_in = ARW'(MAX_ROWS);
         end else begin
            active_rows_in = ARW'(rows_raw);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_cols_ff <= ACW'(COLS_RESET);
         active_rows_ff <= ARW'(ROWS_RESET);
      end else begin
         active_cols_ff <= active_cols_in;
         active_rows_ff <= active_rows_in;
      end
   end

   // Direction generator.
   fsgs_dir_lfsr u_dir_lfsr (
      .clock    (clock),
      .reset    (reset),
      .load     (seed_load),
      .seed     (csr_data),
      .step     (lfsr_step),
      .next_bit (lfsr_bit)
   );

   // Command transfer: one item in the engine at a time.
   assign req_stall = !eng_status.idle;
   assign start     = req_valid && !req_stall;
   assign req.cmd   = req_cmd;
   assign req.col   = req_col;
   assign req.row   = req_row;
   assign req.value = req_value;

   fsgs_grid_engine #(
      .MAX_COLS  (MAX_COLS),
      .MAX_ROWS  (MAX_ROWS),
      .CELL_BITS (CELL_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req         (req),
      .active_cols (active_cols_ff),
      .active_rows (active_rows_ff),
      .res_take    (res_take),
      .lfsr_bit    (lfsr_bit),
      .lfsr_step   (lfsr_step),
      .status      (eng_status),
      .result      (eng_result)
   );

   // Output register: loads a finished result when it is empty or draining.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign res_take = eng_status.done && rsp_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = eng_result;
      end else if (rsp_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_value   = rsp_ff.read_value;
   assign rsp_out_of_range = rsp_ff.out_of_range;

endmodule

[hw/rtl/fsgs_grid_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Falling sand grid step: grid memory bank
// Synchronous memory with one write port and one read port; the read data
// is registered and holds while no read is issued.
// ----------------------------------------------------------------------------
module fsgs_grid_ram #(
   parameter int ADDR_W = 13,
   parameter int DATA_W = 9
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/fsgs_dir_lfsr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Falling sand grid step: direction generator
// 32-bit right-shifting Galois LFSR. It steps once per grain and offers the
// low bit of its next state as the side to try first.
// ----------------------------------------------------------------------------
module fsgs_dir_lfsr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [fsgs_pkg::LFSR_W-1:0]   seed,
   input  logic                          step,
   output logic                          next_bit
);

   import fsgs_pkg::*;

   logic [LFSR_W-1:0] state_ff;
   logic [LFSR_W-1:0] state_in;
   logic [LFSR_W-1:0] stepped;

   // One shift with feedback.
   always_comb begin
      stepped = {1'b0, state_ff[LFSR_W-1:1]};
      if (state_ff[0]) begin
         stepped = stepped ^ LFSR_TAPS;
      end
   end

   // A seed load takes precedence; a zero seed is loaded as one.
   always_comb begin
      state_in = state_ff;
      if (load) begin
         state_in = (seed == '0) ? LFSR_W'(1) : seed;
      end else if (step) begin
         state_in = stepped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEED_DEFAULT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign next_bit = stepped[0];

endmodule

[hw/rtl/fsgs_grid_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Falling sand grid step: grid engine
// Holds the grid in two memory banks. Reads and writes single cells, and runs
// a generation by scanning the current bank column by column while placing
// grains into the other bank, which is zero at the start of every tick. The
// current bank is cleared behind the scan, two columns back, so that the
// banks can swap at the end of the tick.
// ----------------------------------------------------------------------------
module fsgs_grid_engine #(
   parameter int MAX_COLS  = 128,
   parameter int MAX_ROWS  = 64,
   parameter int CELL_BITS = 9
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  fsgs_pkg::cmd_req_type            req,
   input  logic [$clog2(MAX_COLS+1)-1:0]    active_cols,
   input  logic [$clog2(MAX_ROWS+1)-1:0]    active_rows,
   input  logic                             res_take,
   input  logic                             lfsr_bit,
   output logic                             lfsr_step,
   output fsgs_pkg::eng_status_type         status,
   output fsgs_pkg::result_type             result
);

   import fsgs_pkg::*;

   localparam int CW  = $clog2(MAX_COLS);
   localparam int RW  = $clog2(MAX_ROWS);
   localparam int AW  = CW + RW;
   localparam int ACW = $clog2(MAX_COLS + 1);
   localparam int ARW = $clog2(MAX_ROWS + 1);

   localparam logic [3:0] ST_INIT   = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_READ   = 4'd2;
   localparam logic [3:0] ST_SELF   = 4'd3;
   localparam logic [3:0] ST_BELOW  = 4'd4;
   localparam logic [3:0] ST_FIRST  = 4'd5;
   localparam logic [3:0] ST_SECOND = 4'd6;
   localparam logic [3:0] ST_FLUSH  = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   logic [3:0]           state_ff, state_in;
   logic                 bank_ff, bank_in;
   logic [CW-1:0]        sc_ff, sc_in;
   logic [RW-1:0]        sr_ff, sr_in;
   logic [AW:0]          clr_cnt_ff, clr_cnt_in;
   logic [CELL_BITS-1:0] grain_ff, grain_in;
   logic [CW-1:0]        first_col_ff, first_col_in;
   logic [CW-1:0]        second_col_ff, second_col_in;
   logic                 has_first_ff, has_first_in;
   logic                 has_second_ff, has_second_in;
   result_type           res_ff, res_in;

   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic                 cur_we;
   logic [AW-1:0]        cur_waddr;
   logic [CELL_BITS-1:0] cur_wdata;
   logic                 nxt_we;
   logic [AW-1:0]        nxt_waddr;
   logic [CELL_BITS-1:0] nxt_wdata;
   logic                 we0, we1;
   logic [AW-1:0]        waddr0, waddr1;
   logic [CELL_BITS-1:0] wdata0, wdata1;
   logic [CELL_BITS-1:0] rdata0, rdata1, rdata;

   logic                 cell_done;
   logic                 row_last;
   logic                 col_last;
   logic                 clr_done;
   logic                 clr_ok;
   logic                 scanning;
   logic                 req_oor;
   logic [RW-1:0]        below_row;
   logic [CW-1:0]        req_c;
   logic [RW-1:0]        req_r;

   // Cursor and clear pointer status.
   assign row_last  = (ARW'(sr_ff) + ARW'(1)) >= active_rows;
   assign col_last  = (ACW'(sc_ff) + ACW'(1)) >= active_cols;
   assign below_row = sr_ff + RW'(1);
   assign clr_done  = clr_cnt_ff[AW];
   assign clr_ok    = ((CW+1)'(clr_cnt_ff[AW-1:RW]) + (CW+1)'(2)) <= (CW+1)'(sc_ff);
   assign scanning  = (state_ff == ST_SELF) || (state_ff == ST_BELOW) ||
                      (state_ff == ST_FIRST) || (state_ff == ST_SECOND);

   // Single cell access decode.
   assign req_oor = (32'(req.col) >= 32'(active_cols)) || (32'(req.row) >= 32'(active_rows));
   assign req_c   = CW'(req.col);
   assign req_r   = RW'(req.row);

   // Sequencer: cell access, generation scan and clearing.
   always_comb begin
      state_in      = state_ff;
      bank_in       = bank_ff;
      sc_in         = sc_ff;
      sr_in         = sr_ff;
      clr_cnt_in    = clr_cnt_ff;
      grain_in      = grain_ff;
      first_col_in  = first_col_ff;
      second_col_in = second_col_ff;
      has_first_in  = has_first_ff;
      has_second_in = has_second_ff;
      res_in        = res_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      cur_we        = 1'b0;
      cur_waddr     = clr_cnt_ff[AW-1:0];
      cur_wdata     = '0;
      nxt_we        = 1'b0;
      nxt_waddr     = {sc_ff, sr_ff};
      nxt_wdata     = grain_ff;
      lfsr_step     = 1'b0;
      cell_done     = 1'b0;

      // Clear the retiring bank behind the scan.
      if (scanning && !clr_done && clr_ok) begin
         cur_we     = 1'b1;
         clr_cnt_in = clr_cnt_ff + (AW+1)'(1);
      end

      unique case (state_ff)
         ST_INIT: begin
            cur_we     = 1'b1;
            nxt_we     = 1'b1;
            nxt_waddr  = clr_cnt_ff[AW-1:0];
            nxt_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + (AW+1)'(1);
            if (clr_done) begin
               cur_we   = 1'b0;
               nxt_we   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               res_in = '0;
               case (req.cmd)
                  CMD_TICK: begin
                     sc_in      = '0;
                     sr_in      = '0;
                     clr_cnt_in = '0;
                     rd_en      = 1'b1;
                     rd_addr    = '0;
                     state_in   = ST_SELF;
                  end
                  CMD_WRITE: begin
                     res_in.out_of_range = req_oor;
                     cur_we    = !req_oor;
                     cur_waddr = {req_c, req_r};
                     cur_wdata = CELL_BITS'(req.value);
                     state_in  = ST_DONE;
                  end
                  CMD_READ: begin
                     res_in.out_of_range = req_oor;
                     if (req_oor) begin
                        state_in = ST_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = {req_c, req_r};
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_READ: begin
            res_in.read_value = VALUE_W'(rdata);
            state_in          = ST_DONE;
         end
         ST_SELF: begin
            if (rdata == '0) begin
               cell_done = 1'b1;
            end else begin
               // A grain: draw the side to try first.
               lfsr_step = 1'b1;
               grain_in  = rdata;
               if (lfsr_bit) begin
                  first_col_in  = sc_ff - CW'(1);
                  has_first_in  = (sc_ff != '0);
                  second_col_in = sc_ff + CW'(1);
                  has_second_in = !col_last;
               end else begin
                  first_col_in  = sc_ff + CW'(1);
                  has_first_in  = !col_last;
                  second_col_in = sc_ff - CW'(1);
                  has_second_in = (sc_ff != '0);
               end
               if (row_last) begin
                  nxt_we    = 1'b1;
                  nxt_waddr = {sc_ff, sr_ff};
                  nxt_wdata = rdata;
                  cell_done = 1'b1;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = {sc_ff, below_row};
                  state_in = ST_BELOW;
               end
            end
         end
         ST_BELOW: begin
            if (rdata == '0) begin
               nxt_we    = 1'b1;
               nxt_waddr = {sc_ff, below_row};
               cell_done = 1'b1;
            end else if (has_first_ff) begin
               rd_en    = 1'b1;
               rd_addr  = {first_col_ff, below_row};
               state_in = ST_FIRST;
            end else if (has_second_ff) begin
               rd_en    = 1'b1;
               rd_addr  = {second_col_ff, below_row};
               state_in = ST_SECOND;
            end else begin
               nxt_we    = 1'b1;
               cell_done = 1'b1;
            end
         end
         ST_FIRST: begin
            if (rdata == '0) begin
               nxt_we    = 1'b1;
               nxt_waddr = {first_col_ff, below_row};
               cell_done = 1'b1;
            end else if (has_second_ff) begin
               rd_en    = 1'b1;
               rd_addr  = {second_col_ff, below_row};
               state_in = ST_SECOND;
            end else begin
               nxt_we    = 1'b1;
               cell_done = 1'b1;
            end
         end
         ST_SECOND: begin
            nxt_we = 1'b1;
            if (rdata == '0) begin
               nxt_waddr = {second_col_ff, below_row};
            end
            cell_done = 1'b1;
         end
         ST_FLUSH: begin
            if (clr_done) begin
               bank_in  = !bank_ff;
               res_in   = '0;
               state_in = ST_DONE;
            end else begin
               cur_we     = 1'b1;
               clr_cnt_in = clr_cnt_ff + (AW+1)'(1);
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Move the scan cursor on and fetch the next cell.
      if (cell_done) begin
         if (row_last && col_last) begin
            state_in = ST_FLUSH;
         end else begin
            if (row_last) begin
               sc_in = sc_ff + CW'(1);
               sr_in = '0;
            end else begin
               sr_in = below_row;
            end
            rd_en    = 1'b1;
            rd_addr  = {sc_in, sr_in};
            state_in = ST_SELF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         bank_ff    <= 1'b0;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bank_ff    <= bank_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sc_ff         <= sc_in;
      sr_ff         <= sr_in;
      grain_ff      <= grain_in;
      first_col_ff  <= first_col_in;
      second_col_ff <= second_col_in;
      has_first_ff  <= has_first_in;
      has_second_ff <= has_second_in;
      res_ff        <= res_in;
   end

   // Bank steering: the current bank is read, the other one collects the
   // new generation.
   assign we0    = bank_ff ? nxt_we    : cur_we;
   assign waddr0 = bank_ff ? nxt_waddr : cur_waddr;
   assign wdata0 = bank_ff ? nxt_wdata : cur_wdata;
   assign we1    = bank_ff ? cur_we    : nxt_we;
   assign waddr1 = bank_ff ? cur_waddr : nxt_waddr;
   assign wdata1 = bank_ff ? cur_wdata : nxt_wdata;
   assign rdata  = bank_ff ? rdata1    : rdata0;

   fsgs_grid_ram #(
      .ADDR_W (AW),
      .DATA_W (CELL_BITS)
   ) u_bank0 (
      .clock (clock),
      .we    (we0),
      .waddr (waddr0),
      .wdata (wdata0),
      .re    (rd_en && !bank_ff),
      .raddr (rd_addr),
      .rdata (rdata0)
   );

   fsgs_grid_ram #(
      .ADDR_W (AW),
      .DATA_W (CELL_BITS)
   ) u_bank1 (
      .clock (clock),
      .we    (we1),
      .waddr (waddr1),
      .wdata (wdata1),
      .re    (rd_en && bank_ff),
      .raddr (rd_addr),
      .rdata (rdata1)
   );

   assign status.idle = (state_ff == ST_IDLE);
   assign status.done = (state_ff == ST_DONE);
   assign result      = res_ff;

   // The engine goes idle once the reset clearing pass has finished.
   a_init_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT && clr_done) |=> (state_ff == ST_IDLE))
      else $error("engine did not leave the clearing pass");

   // The banks swap only at the end of a tick whose clearing is complete.
   a_swap_at_end: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && bank_ff != $past(bank_ff)) |->
      ($past(state_ff) == ST_FLUSH && $past(clr_done)))
      else $error("grid banks swapped outside the end of a tick");

   // Every placement lands inside the active grid.
   a_place_in_grid: assert property (@(posedge clock) disable iff (reset)
      (nxt_we && state_ff != ST_INIT) |->
      (32'(nxt_waddr[AW-1:RW]) < 32'(active_cols) &&
       32'(nxt_waddr[RW-1:0]) < 32'(active_rows)))
      else $error("grain placed outside the active grid");

   // A finished result holds until the output side takes it.
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !res_take) |=> (state_ff == ST_DONE && $stable(res_ff)))
      else $error("result changed before transfer");

endmodule
